FILE: sv/erg_pkg.sv
`timescale 1ns / 1ps

package erg_pkg;

    localparam int MAX_STEPS_DEFAULT = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_COUNT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SCHMITT_HIGH  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SCHMITT_LOW   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_SAMPLES = CFG_IDX_W'(5);

    localparam logic [6:0]         RST_STEP_COUNT    = 7'd16;
    localparam logic [6:0]         RST_PULSE_COUNT   = 7'd4;
    localparam logic signed [7:0]  RST_ROTATION      = 8'sd0;
    localparam logic signed [14:0] RST_SCHMITT_HIGH  = 15'sd1000;
    localparam logic signed [14:0] RST_SCHMITT_LOW   = 15'sd100;
    localparam logic [15:0]        RST_PULSE_SAMPLES = 16'd48;

    typedef struct packed {
        logic [6:0]         step_count;
        logic [6:0]         pulse_count;
        logic signed [7:0]  rotation;
        logic signed [14:0] schmitt_high_mv;
        logic signed [14:0] schmitt_low_mv;
        logic [15:0]        pulse_samples;
    } cfg_t;

    typedef enum logic [1:0] {
        MOD_SRC_IDX,
        MOD_SRC_PROD,
        MOD_SRC_ADV
    } mod_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DETECT,
        ST_IDX_GO,
        ST_IDX_WAIT,
        ST_PROD_GO,
        ST_PROD_WAIT,
        ST_ADV_GO,
        ST_ADV_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        logic     detect;
        logic     mod_start;
        mod_sel_t mod_sel;
        logic     take_idx;
        logic     take_hit;
        logic     take_adv;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic clk_edge;
        logic steps_zero;
        logic mod_done;
        logic out_free;
    } status_t;

endpackage

FILE: sv/erg_if.sv
`timescale 1ns / 1ps

interface erg_in_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] clock_mv;
    logic signed [14:0] reset_mv;

    modport source (output valid, output clock_mv, output reset_mv, input ready);
    modport sink   (input valid, input clock_mv, input reset_mv, output ready);
endinterface

interface erg_out_if;
    logic valid;
    logic ready;
    logic gate;

    modport source (output valid, output gate, input ready);
    modport sink   (input valid, input gate, output ready);
endinterface

FILE: sv/erg_cfg.sv
`timescale 1ns / 1ps

module erg_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [erg_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [erg_pkg::CFG_DATA_W-1:0] wr_data,
    output erg_pkg::cfg_t                  cfg
);
    import erg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_STEP_COUNT:    cfg_next.step_count      = wr_data[6:0];
                REG_PULSE_COUNT:   cfg_next.pulse_count     = wr_data[6:0];
                REG_ROTATION:      cfg_next.rotation        = wr_data[7:0];
                REG_SCHMITT_HIGH:  cfg_next.schmitt_high_mv = wr_data[14:0];
                REG_SCHMITT_LOW:   cfg_next.schmitt_low_mv  = wr_data[14:0];
                REG_PULSE_SAMPLES: cfg_next.pulse_samples   = wr_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_count      <= RST_STEP_COUNT;
            cfg_reg.pulse_count     <= RST_PULSE_COUNT;
            cfg_reg.rotation        <= RST_ROTATION;
            cfg_reg.schmitt_high_mv <= RST_SCHMITT_HIGH;
            cfg_reg.schmitt_low_mv  <= RST_SCHMITT_LOW;
            cfg_reg.pulse_samples   <= RST_PULSE_SAMPLES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/erg_mod.sv
`timescale 1ns / 1ps

module erg_mod #(
    parameter int DIV_W  = 14,
    parameter int STEP_W = 7
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [STEP_W-1:0] divisor,
    output logic [STEP_W-1:0] remainder,
    output logic              done
);
    localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [STEP_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [STEP_W:0]   trial;
    logic [STEP_W:0]   diff;
    logic [STEP_W-1:0] rem_step;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIV_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        rem_step = (trial >= {1'b0, dvs_reg}) ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
    end

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract if it fits
            dvd_next = dvd_reg << 1;
            rem_next = rem_step;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

FILE: sv/erg_datapath.sv
`timescale 1ns / 1ps

module erg_datapath #(
    parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  erg_pkg::cfg_t      cfg,
    input  erg_pkg::cmd_t      cmd,
    output erg_pkg::status_t   status,
    input  logic signed [14:0] clock_mv,
    input  logic signed [14:0] reset_mv,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               gate
);
    import erg_pkg::*;

    localparam int STEP_W  = $clog2(MAX_STEPS + 1);
    localparam int POS_W   = $clog2(MAX_STEPS);
    localparam int PROD_W  = 2 * STEP_W;
    localparam int IDX_MAX = 129 * MAX_STEPS + 127;
    localparam int IDX_W   = $clog2(IDX_MAX + 1);
    localparam int DIV_W   = (IDX_W > PROD_W) ? IDX_W : PROD_W;

    logic signed [14:0] clock_s_reg, clock_s_next;
    logic signed [14:0] reset_s_reg, reset_s_next;
    logic               clock_latched_reg, clock_latched_next;
    logic               reset_latched_reg, reset_latched_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   idx_reg, idx_next;
    logic [15:0]        remain_reg, remain_next;
    logic               out_valid_reg, out_valid_next;
    logic               gate_reg, gate_next;

    logic signed [7:0]  rot;
    logic signed [14:0] thr_high;
    logic signed [14:0] thr_low;
    logic [STEP_W-1:0]  steps;
    logic [STEP_W-1:0]  pulses;
    logic               clk_edge;
    logic               rst_edge;

    logic [DIV_W-1:0]   steps_x128;
    logic signed [DIV_W:0] rot_ext;
    logic signed [DIV_W:0] idx_sum;
    logic [DIV_W-1:0]   prod;
    logic [DIV_W-1:0]   adv;
    logic [DIV_W-1:0]   dividend;
    logic [STEP_W-1:0]  mod_rem;
    logic               mod_done;
    logic               hit;

    assign rot      = cfg.rotation;
    assign thr_high = cfg.schmitt_high_mv;
    assign thr_low  = cfg.schmitt_low_mv;

    always_comb
    begin
        if (int'(cfg.step_count) > MAX_STEPS)
            steps = STEP_W'(MAX_STEPS);
        else
            steps = STEP_W'(cfg.step_count);
        if (int'(cfg.pulse_count) > int'(steps))
            pulses = steps;
        else
            pulses = STEP_W'(cfg.pulse_count);
    end

    assign rst_edge = !reset_latched_reg && (reset_s_reg >= thr_high);
    assign clk_edge = !clock_latched_reg && (clock_s_reg >= thr_high);

    // bias by 128 * steps keeps the rotated index non-negative
    assign steps_x128 = DIV_W'(steps) << 7;
    assign rot_ext    = (DIV_W + 1)'(rot);
    assign idx_sum    = $signed({1'b0, DIV_W'(pos_reg)}) + $signed({1'b0, steps_x128}) - rot_ext;
    assign prod       = DIV_W'(idx_reg) * DIV_W'(pulses);
    assign adv        = DIV_W'(pos_reg) + DIV_W'(1);

    always_comb
    begin
        case (cmd.mod_sel)
            MOD_SRC_IDX:  dividend = idx_sum[DIV_W-1:0];
            MOD_SRC_PROD: dividend = prod;
            MOD_SRC_ADV:  dividend = adv;
            default:      dividend = adv;
        endcase
    end

    erg_mod #(
        .DIV_W  (DIV_W),
        .STEP_W (STEP_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mod_start),
        .dividend  (dividend),
        .divisor   (steps),
        .remainder (mod_rem),
        .done      (mod_done)
    );

    assign hit = (pulses != '0) && (mod_rem < pulses);

    always_comb
    begin
        clock_s_next       = clock_s_reg;
        reset_s_next       = reset_s_reg;
        clock_latched_next = clock_latched_reg;
        reset_latched_next = reset_latched_reg;
        pos_next           = pos_reg;
        idx_next           = idx_reg;
        remain_next        = remain_reg;
        out_valid_next     = out_valid_reg;
        gate_next          = gate_reg;

        if (cmd.load)
        begin
            clock_s_next = clock_mv;
            reset_s_next = reset_mv;
        end

        if (cmd.detect)
        begin
            if (rst_edge)
                reset_latched_next = 1'b1;
            else if (reset_latched_reg && (reset_s_reg <= thr_low))
                reset_latched_next = 1'b0;
            if (clk_edge)
                clock_latched_next = 1'b1;
            else if (clock_latched_reg && (clock_s_reg <= thr_low))
                clock_latched_next = 1'b0;
            if (rst_edge || (clk_edge && (steps == '0)))
                pos_next = '0;
        end

        if (cmd.take_idx)
            idx_next = mod_rem[POS_W-1:0];

        if (cmd.take_adv)
            pos_next = mod_rem[POS_W-1:0];

        if (cmd.take_hit)
        begin
            if (hit && (cfg.pulse_samples > remain_reg))
                remain_next = cfg.pulse_samples;
        end
        else if (cmd.finish)
        begin
            if (remain_reg != '0)
                remain_next = remain_reg - 16'd1;
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            gate_next      = (remain_reg != '0);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_latched_reg <= 1'b0;
            reset_latched_reg <= 1'b0;
            pos_reg           <= '0;
            remain_reg        <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            clock_latched_reg <= clock_latched_next;
            reset_latched_reg <= reset_latched_next;
            pos_reg           <= pos_next;
            remain_reg        <= remain_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clock_s_reg <= clock_s_next;
        reset_s_reg <= reset_s_next;
        idx_reg     <= idx_next;
        gate_reg    <= gate_next;
    end

    assign status.clk_edge   = clk_edge;
    assign status.steps_zero = (steps == '0);
    assign status.mod_done   = mod_done;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign gate      = gate_reg;

endmodule

FILE: sv/erg_ctrl.sv
`timescale 1ns / 1ps

module erg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  erg_pkg::status_t status,
    output erg_pkg::cmd_t    cmd
);
    import erg_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DETECT;
            end
            ST_DETECT:
            begin
                if (status.clk_edge && !status.steps_zero)
                    state_next = ST_IDX_GO;
                else
                    state_next = ST_FINISH;
            end
            ST_IDX_GO:    state_next = ST_IDX_WAIT;
            ST_IDX_WAIT:
            begin
                if (status.mod_done)
                    state_next = ST_PROD_GO;
            end
            ST_PROD_GO:   state_next = ST_PROD_WAIT;
            ST_PROD_WAIT:
            begin
                if (status.mod_done)
                    state_next = ST_ADV_GO;
            end
            ST_ADV_GO:    state_next = ST_ADV_WAIT;
            ST_ADV_WAIT:
            begin
                if (status.mod_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DETECT:
            begin
                cmd.detect = 1'b1;
            end
            ST_IDX_GO:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_sel   = MOD_SRC_IDX;
            end
            ST_IDX_WAIT:
            begin
                cmd.take_idx = status.mod_done;
            end
            ST_PROD_GO:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_sel   = MOD_SRC_PROD;
            end
            ST_PROD_WAIT:
            begin
                cmd.mod_sel  = MOD_SRC_PROD;
                cmd.take_hit = status.mod_done;
            end
            ST_ADV_GO:
            begin
                cmd.mod_start = 1'b1;
                cmd.mod_sel   = MOD_SRC_ADV;
            end
            ST_ADV_WAIT:
            begin
                cmd.mod_sel  = MOD_SRC_ADV;
                cmd.take_adv = status.mod_done;
            end
            ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/euclidean_rhythm_gate_top.sv
// Flow: an accepted item passes the detect state, then finish when no clock edge is seen or
//   the length is zero, else the index, pattern and advance remainder passes, then finish.
// Items: one at a time, the next taken after finish registers the result; finish waits on a
//   stalled output. The remainder unit is serial, one dividend bit (of 14 at MAX_STEPS 64) per cycle.
// Reset: rst_n asynchronous, active low; reset registers take defaults at once, no clear pass.
`timescale 1ns / 1ps

module euclidean_rhythm_gate_top #(
    parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    erg_in_if.sink                         samples,
    erg_out_if.source                      gates,
    input  logic                           wr_en,
    input  logic [erg_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [erg_pkg::CFG_DATA_W-1:0] wr_data
);
    import erg_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    logic in_valid_w;
    logic in_ready_w;
    logic out_valid_w;
    logic out_ready_w;
    logic gate_w;

    assign in_valid_w    = samples.valid;
    assign samples.ready = in_ready_w;
    assign out_ready_w   = gates.ready;
    assign gates.valid   = out_valid_w;
    assign gates.gate    = gate_w;

    erg_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    erg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid_w),
        .in_ready (in_ready_w),
        .status   (status),
        .cmd      (cmd)
    );

    erg_datapath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .clock_mv  (samples.clock_mv),
        .reset_mv  (samples.reset_mv),
        .out_ready (out_ready_w),
        .out_valid (out_valid_w),
        .gate      (gate_w)
    );

endmodule

FILE: sv/erg_checker.sv
`timescale 1ns / 1ps

module erg_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic gate
);

    // one item at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready stayed high after an accepted item");

    // a result needs at least the detect cycle after its accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result appeared without detect cycle");

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(gate)))
        else $error("stalled result changed or dropped");

endmodule

bind euclidean_rhythm_gate_top erg_checker u_erg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid_w),
    .in_ready  (in_ready_w),
    .out_valid (out_valid_w),
    .out_ready (out_ready_w),
    .gate      (gate_w)
);

FILE: bench/euclidean_rhythm_gate_top_tb.sv
`timescale 1ns / 1ps

module euclidean_rhythm_gate_top_tb;

    import erg_pkg::*;

    localparam int MAX_STEPS     = MAX_STEPS_DEFAULT;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 5000;
    localparam int MV_MIN        = -16384;
    localparam int MV_MAX        = 16383;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(7);

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    erg_in_if  samples_if();
    erg_out_if gates_if();

    euclidean_rhythm_gate_top #(
        .MAX_STEPS(MAX_STEPS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .samples(samples_if),
        .gates(gates_if),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data)
    );

    cfg_t live_cfg;
    bit   clk_latched;
    bit   rst_latched;
    int   step_pos;
    int   trigger_left;

    bit gate_expect_q[$];

    int send_gap_pct;
    int recv_stall_pct;
    int mismatches;
    int samples_sent;
    int gates_seen;
    int gates_high;
    int hits_predicted;
    int reg_writes;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic bit schmitt_edge(inout bit latched, input int v);
        if (!latched && v >= int'(live_cfg.schmitt_high_mv))
        begin
            latched = 1'b1;
            return 1'b1;
        end
        if (latched && v <= int'(live_cfg.schmitt_low_mv))
            latched = 1'b0;
        return 1'b0;
    endfunction

    function automatic bit rhythm_tick(int clock_v, int reset_v);
        int steps;
        int pulses;
        int idx;
        bit hit;
        steps = (int'(live_cfg.step_count) > MAX_STEPS) ? MAX_STEPS : int'(live_cfg.step_count);
        if (schmitt_edge(rst_latched, reset_v))
            step_pos = 0;
        if (schmitt_edge(clk_latched, clock_v))
        begin
            hit = 1'b0;
            if (steps != 0 && live_cfg.pulse_count != 0)
            begin
                pulses = (int'(live_cfg.pulse_count) > steps) ? steps : int'(live_cfg.pulse_count);
                idx = (step_pos - int'(live_cfg.rotation)) % steps;
                idx = (idx + steps) % steps;
                hit = ((idx * pulses) % steps) < pulses;
            end
            if (hit)
                hits_predicted++;
            if (hit && int'(live_cfg.pulse_samples) > trigger_left)
                trigger_left = int'(live_cfg.pulse_samples);
            step_pos = (steps > 0) ? (step_pos + 1) % steps : 0;
        end
        if (trigger_left > 0)
        begin
            trigger_left--;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic cfg_t make_cfg(int steps, int pulses, int rot, int high, int low,
                                      int len);
        cfg_t c;
        c.step_count      = 7'(steps);
        c.pulse_count     = 7'(pulses);
        c.rotation        = 8'(rot);
        c.schmitt_high_mv = 15'(high);
        c.schmitt_low_mv  = 15'(low);
        c.pulse_samples   = 16'(len);
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t c;
        int   steps;
        int   high;
        c.rotation = 8'($urandom);
        case ($urandom_range(9))
            0: steps = 0;
            1: steps = 64;
            2: steps = $urandom_range(65, 127);
            default: steps = $urandom_range(1, 16);
        endcase
        c.step_count = 7'(steps);
        case ($urandom_range(9))
            0: c.pulse_count = 7'd0;
            1: c.pulse_count = 7'($urandom_range(127));
            default: c.pulse_count = 7'($urandom_range(1, ((steps > MAX_STEPS) ? MAX_STEPS
                                                              : steps) + 1));
        endcase
        if ($urandom_range(4) == 0)
        begin
            c.schmitt_high_mv = 15'($urandom);
            c.schmitt_low_mv  = 15'($urandom);
        end
        else
        begin
            high = $urandom_range(200, 6000);
            c.schmitt_high_mv = 15'(high);
            c.schmitt_low_mv  = 15'(high - int'($urandom_range(3000)));
        end
        case ($urandom_range(15))
            0: c.pulse_samples = 16'd0;
            1: c.pulse_samples = 16'($urandom_range(20, 300));
            default: c.pulse_samples = 16'($urandom_range(1, 6));
        endcase
        return c;
    endfunction

    function automatic logic signed [14:0] level_for(bit above);
        int lo;
        int hi;
        if (above)
        begin
            lo = int'(live_cfg.schmitt_high_mv);
            hi = MV_MAX;
        end
        else
        begin
            lo = MV_MIN;
            hi = int'(live_cfg.schmitt_low_mv);
        end
        return 15'(lo + int'($urandom_range(hi - lo)));
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            REG_STEP_COUNT:    live_cfg.step_count      = data[6:0];
            REG_PULSE_COUNT:   live_cfg.pulse_count     = data[6:0];
            REG_ROTATION:      live_cfg.rotation        = data[7:0];
            REG_SCHMITT_HIGH:  live_cfg.schmitt_high_mv = data[14:0];
            REG_SCHMITT_LOW:   live_cfg.schmitt_low_mv  = data[14:0];
            REG_PULSE_SAMPLES: live_cfg.pulse_samples   = data;
            default: ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic program_config(cfg_t c);
        write_reg(REG_STEP_COUNT, {9'd0, c.step_count});
        write_reg(REG_PULSE_COUNT, {9'd0, c.pulse_count});
        write_reg(REG_ROTATION, {{8{c.rotation[7]}}, c.rotation});
        write_reg(REG_SCHMITT_HIGH, {c.schmitt_high_mv[14], c.schmitt_high_mv});
        write_reg(REG_SCHMITT_LOW, {c.schmitt_low_mv[14], c.schmitt_low_mv});
        write_reg(REG_PULSE_SAMPLES, c.pulse_samples);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(logic signed [14:0] clock_v, logic signed [14:0] reset_v);
        while ($urandom_range(99) < send_gap_pct)
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid    <= 1'b1;
        samples_if.clock_mv <= clock_v;
        samples_if.reset_mv <= reset_v;
        do
            @(posedge clk);
        while (!samples_if.ready);
        gate_expect_q.push_back(rhythm_tick(int'(clock_v), int'(reset_v)));
        samples_sent++;
    endtask

    // hold input until every gate result is back, then let the block go idle
    task automatic settle();
        samples_if.valid <= 1'b0;
        while (gate_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_power_on_defaults();
        send_sample(15'sd0, 15'sd0);
        send_sample(15'sd1000, 15'sd0);
        send_sample(15'sd100, 15'sd0);
        send_sample(15'sd999, 15'sd0);
        send_sample(15'(MV_MAX), 15'(MV_MIN));
        send_sample(15'(MV_MIN), 15'(MV_MAX));
        settle();
    endtask

    task automatic test_clamp_and_retrigger();
        program_config(make_cfg(3, 5, -128, 0, 0, 3));
        send_sample(15'(MV_MAX), 15'(MV_MAX));
        send_sample(-15'sd1, -15'sd1);
        send_sample(15'sd0, -15'sd1);
        send_sample(15'(MV_MIN), 15'sd0);
        send_sample(15'sd0, -15'sd1);
        settle();
    endtask

    task automatic test_silent_lengths();
        program_config(make_cfg(0, 4, 127, MV_MIN, MV_MAX, 65535));
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h5A5A);
        wr_en <= 1'b0;
        @(posedge clk);
        send_sample(15'(MV_MIN), 15'(MV_MIN));
        send_sample(15'sd0, 15'sd0);
        send_sample(15'(MV_MAX), 15'(MV_MAX));
        settle();
        program_config(make_cfg(127, 127, 64, 1, -1, 0));
        send_sample(15'sd1, 15'sd0);
        send_sample(-15'sd1, 15'sd0);
        send_sample(15'sd5000, 15'sd0);
        send_sample(-15'sd5000, 15'sd0);
        settle();
    endtask

    task automatic test_shrunk_length();
        program_config(make_cfg(5, 2, -64, 0, 0, 2));
        repeat (3)
        begin
            send_sample(15'sd1, -15'sd1);
            send_sample(-15'sd1, -15'sd1);
        end
        settle();
        program_config(make_cfg(2, 2, -64, 0, 0, 2));
        send_sample(15'sd1, -15'sd1);
        send_sample(-15'sd1, -15'sd1);
        send_sample(15'sd1, -15'sd1);
        settle();
    endtask

    task automatic test_random_patterns(int n_cfg, int n_samples);
        bit                 clk_up;
        bit                 rst_up;
        int                 clk_hold;
        int                 rst_hold;
        logic signed [14:0] cv;
        logic signed [14:0] rv;
        clk_up   = 1'b0;
        clk_hold = 0;
        rst_hold = 0;
        repeat (n_cfg)
        begin
            program_config(random_cfg());
            repeat (n_samples)
            begin
                if (clk_hold == 0)
                begin
                    clk_up   = !clk_up;
                    clk_hold = $urandom_range(1, 3);
                end
                clk_hold--;
                rst_up = 1'b0;
                if (rst_hold > 0)
                begin
                    rst_up = 1'b1;
                    rst_hold--;
                end
                else if ($urandom_range(49) == 0)
                begin
                    rst_up   = 1'b1;
                    rst_hold = $urandom_range(0, 2);
                end
                cv = level_for(clk_up);
                rv = level_for(rst_up);
                if ($urandom_range(9) == 0)
                    cv = 15'($urandom);
                if ($urandom_range(9) == 0)
                    rv = 15'($urandom);
                send_sample(cv, rv);
            end
            settle();
        end
    endtask

    task automatic test_long_trigger();
        program_config(make_cfg(1, 1, 0, 1000, 100, 65535));
        send_sample(15'sd2000, 15'sd0);
        send_sample(15'sd0, 15'sd0);
        send_sample(15'sd2000, 15'sd0);
        settle();
    endtask

    always @(posedge clk)
    begin
        gates_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        bit exp_gate;
        if (rst_n && gates_if.valid && gates_if.ready)
        begin
            gates_seen++;
            if (gates_if.gate)
                gates_high++;
            if (gate_expect_q.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected gate result: expected none, actual %0b",
                         $time, gates_if.gate);
            end
            else
            begin
                exp_gate = gate_expect_q.pop_front();
                if (exp_gate !== gates_if.gate)
                begin
                    mismatches++;
                    $display("%0t gate mismatch: expected %0b, actual %0b",
                             $time, exp_gate, gates_if.gate);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((samples_if.valid && samples_if.ready) || (gates_if.valid && gates_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t watchdog: no item moved for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        wr_en               = 1'b0;
        wr_index            = '0;
        wr_data             = '0;
        samples_if.valid    = 1'b0;
        samples_if.clock_mv = '0;
        samples_if.reset_mv = '0;
        gates_if.ready      = 1'b0;
        quiet_cycles        = 0;
        mismatches          = 0;
        samples_sent        = 0;
        gates_seen          = 0;
        gates_high          = 0;
        hits_predicted      = 0;
        reg_writes          = 0;
        live_cfg = make_cfg(int'(RST_STEP_COUNT), int'(RST_PULSE_COUNT), int'(RST_ROTATION),
                            int'(RST_SCHMITT_HIGH), int'(RST_SCHMITT_LOW),
                            int'(RST_PULSE_SAMPLES));
        clk_latched  = 1'b0;
        rst_latched  = 1'b0;
        step_pos     = 0;
        trigger_left = 0;

        send_gap_pct   = 7;
        recv_stall_pct = 81;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_clamp_and_retrigger();
        test_silent_lengths();
        test_shrunk_length();
        test_random_patterns(4, 105);

        send_gap_pct   = 81;
        recv_stall_pct = 7;
        test_random_patterns(4, 105);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_patterns(4, 105);
        test_long_trigger();

        $display("Covered %0d samples over %0d register writes, random Euclidean patterns",
                 samples_sent, reg_writes);
        $display("Checked %0d gate results (%0d high, %0d pattern hits), %0d mismatches",
                 gates_seen, gates_high, hits_predicted, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: euclidean_rhythm_gate_top.f
sv/erg_pkg.sv
sv/erg_if.sv
sv/erg_cfg.sv
sv/erg_mod.sv
sv/erg_datapath.sv
sv/erg_ctrl.sv
sv/euclidean_rhythm_gate_top.sv
sv/erg_checker.sv
bench/euclidean_rhythm_gate_top_tb.sv
